### rtl/core/vwc_pkg.sv
`timescale 1ns / 1ps

package vwc_pkg;

	localparam int SUM_W = 40;
	localparam int CRD_W = 24;
	localparam int HIT_W = 16;
	localparam int RAD_W = 23;
	localparam int IDX_W = 8;
	localparam int STA_W = 3;
	// dividend is |sum| + hits/2, below 2^40
	localparam int DIV_W = 41;
	localparam int REM_W = 17;
	localparam int DCNT_W = 6;

	localparam logic [HIT_W-1:0] HIT_MAX = 16'hFFFF;

	typedef enum logic [1:0] {
		FN_INSERT = 2'd0,
		FN_READ   = 2'd1,
		FN_CLEAR  = 2'd2
	} func_t;

	typedef enum logic [STA_W-1:0] {
		ST_JOIN  = 3'd0,
		ST_NEW   = 3'd1,
		ST_FULL  = 3'd2,
		ST_READ  = 3'd3,
		ST_EMPTY = 3'd4
	} status_t;

	// one cluster table entry; the rounded average is kept next to the sums
	typedef struct packed {
		logic signed [SUM_W-1:0] sum_x;
		logic signed [SUM_W-1:0] sum_y;
		logic signed [SUM_W-1:0] sum_z;
		logic [HIT_W-1:0]        hits;
		logic signed [CRD_W-1:0] avg_x;
		logic signed [CRD_W-1:0] avg_y;
		logic signed [CRD_W-1:0] avg_z;
	} ent_t;

endpackage

### rtl/core/vertex_weld_cluster.sv
`timescale 1ns / 1ps

// Insert scans the stored clusters and opens a new one when none matches; a join at a
//   cluster runs a 41-step divide per axis for the new rounded average, skipped when that
//   cluster is saturated. Read fetches one entry; a bad index or a clear goes straight to
//   the result. One word in flight: ready again as soon as the result is registered, which
//   waits while the output register still holds a word that is not taken.
// Reset clears control, the cluster count and the radius (256); the table is not cleared.
module vertex_weld_cluster import vwc_pkg::*; #(
	parameter int MAX_CLUSTERS = 256
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [RAD_W-1:0]        cfg_wdata,
	input  logic                    vtx_valid,
	output logic                    vtx_ready,
	input  logic [1:0]              func,
	input  logic signed [CRD_W-1:0] pos_x,
	input  logic signed [CRD_W-1:0] pos_y,
	input  logic signed [CRD_W-1:0] pos_z,
	input  logic [IDX_W-1:0]        cluster_sel,
	output logic                    res_valid,
	input  logic                    res_ready,
	output logic [STA_W-1:0]        status,
	output logic [IDX_W-1:0]        cluster_index,
	output logic signed [CRD_W-1:0] avg_x,
	output logic signed [CRD_W-1:0] avg_y,
	output logic signed [CRD_W-1:0] avg_z,
	output logic [HIT_W-1:0]        hit_count
);

	localparam int AW = $clog2(MAX_CLUSTERS);
	localparam int CW = $clog2(MAX_CLUSTERS + 1);
	localparam logic [CW-1:0] CNT_FULL = CW'(MAX_CLUSTERS);

	typedef enum logic [3:0] {
		S_IDLE, S_SCAN, S_MRD, S_MWAIT, S_DINIT, S_DIV, S_WRB, S_RRD, S_RWAIT, S_EMIT
	} state_t;

	function automatic logic [CRD_W:0] abs_diff(logic signed [CRD_W-1:0] a,
		logic signed [CRD_W-1:0] b);
		logic signed [CRD_W:0] d;
		d = $signed({a[CRD_W-1], a}) - $signed({b[CRD_W-1], b});
		return d[CRD_W] ? (CRD_W+1)'(-d) : d;
	endfunction

	// cluster table: read every cycle, one write port
	ent_t mem [MAX_CLUSTERS];
	ent_t rd_q;
	logic [AW-1:0] rd_addr;
	logic wr_en;
	logic [AW-1:0] wr_addr;
	ent_t wr_data;

	state_t state_q;
	logic [RAD_W-1:0] radius_q;
	logic [2*RAD_W-1:0] r2_q;
	logic [CW-1:0] total_q;
	logic [CW-1:0] scan_q;
	logic [AW-1:0] hit_idx_q;
	logic signed [CRD_W-1:0] px_q, py_q, pz_q;
	logic [IDX_W-1:0] sel_q;

	// scan pipeline: s1 = table read, s2 = abs diffs, s3 = squares
	logic v_s1, v_s2, v_s3;
	logic [AW-1:0] idx_s1, idx_s2, idx_s3;
	logic [CRD_W:0] dx_s2, dy_s2, dz_s2;
	logic [2*CRD_W+1:0] sqx_s3, sqy_s3, sqz_s3;
	logic [2*CRD_W+3:0] d2;
	logic issue, match, scan_done;

	// entry being updated, three-lane restoring divider
	ent_t ent_q;
	logic [DIV_W-1:0] dvd_q [3];
	logic [REM_W-1:0] rem_q [3];
	logic [DIV_W-1:0] quo_q [3];
	logic [DCNT_W-1:0] dcnt_q;
	logic signed [SUM_W-1:0] sum_a [3];
	logic [REM_W-1:0] trial [3];
	logic [REM_W-1:0] rem_n [3];
	logic qbit [3];
	logic [SUM_W-1:0] mag [3];
	logic signed [CRD_W-1:0] avg_n [3];

	// staged result and output register
	status_t stg_status_q;
	logic [IDX_W-1:0] stg_idx_q;
	logic signed [CRD_W-1:0] stg_ax_q, stg_ay_q, stg_az_q;
	logic [HIT_W-1:0] stg_hits_q;
	logic res_valid_q;
	logic [STA_W-1:0] status_q;
	logic [IDX_W-1:0] idx_q;
	logic signed [CRD_W-1:0] ax_q, ay_q, az_q;
	logic [HIT_W-1:0] hits_q;

	logic [AW+IDX_W-1:0] sel_ext, hit_ext, tot_ext;
	logic [CW+IDX_W-1:0] sel_cmp, tot_cmp;
	logic signed [SUM_W-1:0] pxe, pye, pze;

	assign sel_ext = {{AW{1'b0}}, sel_q};
	assign hit_ext = {{IDX_W{1'b0}}, hit_idx_q};
	assign tot_ext = {{IDX_W{1'b0}}, total_q[AW-1:0]};
	assign sel_cmp = {{CW{1'b0}}, cluster_sel};
	assign tot_cmp = {{IDX_W{1'b0}}, total_q};
	assign pxe = SUM_W'(px_q);
	assign pye = SUM_W'(py_q);
	assign pze = SUM_W'(pz_q);

	assign vtx_ready = (state_q == S_IDLE);
	assign issue = (state_q == S_SCAN) && (scan_q < total_q);
	assign d2 = {2'b0, sqx_s3} + {2'b0, sqy_s3} + {2'b0, sqz_s3};
	assign match = v_s3 && (d2 <= {6'b0, r2_q});
	assign scan_done = (state_q == S_SCAN) && !issue && !v_s1 && !v_s2 && !v_s3;

	always_comb begin
		unique case (state_q)
			S_SCAN:  rd_addr = scan_q[AW-1:0];
			S_MRD:   rd_addr = hit_idx_q;
			default: rd_addr = sel_ext[AW-1:0];
		endcase
	end

	// divider step and final sign
	always_comb begin
		sum_a[0] = ent_q.sum_x;
		sum_a[1] = ent_q.sum_y;
		sum_a[2] = ent_q.sum_z;
		for (int k = 0; k < 3; k++) begin
			mag[k] = sum_a[k][SUM_W-1] ? SUM_W'(-sum_a[k]) : sum_a[k];
			trial[k] = {rem_q[k][REM_W-2:0], dvd_q[k][DIV_W-1]};
			qbit[k] = (trial[k] >= {1'b0, ent_q.hits});
			rem_n[k] = qbit[k] ? REM_W'(trial[k] - {1'b0, ent_q.hits}) : trial[k];
			avg_n[k] = sum_a[k][SUM_W-1] ? CRD_W'(-quo_q[k][CRD_W-1:0])
				: quo_q[k][CRD_W-1:0];
		end
	end

	always_comb begin
		wr_en = 1'b0;
		wr_addr = hit_idx_q;
		wr_data = ent_q;
		if (state_q == S_WRB) begin
			wr_en = 1'b1;
			wr_data.avg_x = avg_n[0];
			wr_data.avg_y = avg_n[1];
			wr_data.avg_z = avg_n[2];
		end else if (scan_done && total_q != CNT_FULL) begin
			// open a new cluster holding the vertex
			wr_en = 1'b1;
			wr_addr = total_q[AW-1:0];
			wr_data.sum_x = pxe;
			wr_data.sum_y = pye;
			wr_data.sum_z = pze;
			wr_data.hits = HIT_W'(1);
			wr_data.avg_x = px_q;
			wr_data.avg_y = py_q;
			wr_data.avg_z = pz_q;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
		rd_q <= mem[rd_addr];
	end

	// radius and its square; the user must write the radius only while idle, the block does not enforce it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= RAD_W'(256);
			r2_q <= '0;
		end else begin
			if (cfg_we)
				radius_q <= cfg_wdata;
			r2_q <= radius_q * radius_q;
		end
	end

	// datapath of the scan, no control
	always_ff @(posedge clk) begin
		idx_s1 <= scan_q[AW-1:0];
		idx_s2 <= idx_s1;
		dx_s2 <= abs_diff(px_q, rd_q.avg_x);
		dy_s2 <= abs_diff(py_q, rd_q.avg_y);
		dz_s2 <= abs_diff(pz_q, rd_q.avg_z);
		idx_s3 <= idx_s2;
		sqx_s3 <= dx_s2 * dx_s2;
		sqy_s3 <= dy_s2 * dy_s2;
		sqz_s3 <= dz_s2 * dz_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			total_q <= '0;
			scan_q <= '0;
			hit_idx_q <= '0;
			px_q <= '0;
			py_q <= '0;
			pz_q <= '0;
			sel_q <= '0;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			ent_q <= '0;
			for (int k = 0; k < 3; k++) begin
				dvd_q[k] <= '0;
				rem_q[k] <= '0;
				quo_q[k] <= '0;
			end
			dcnt_q <= '0;
			stg_status_q <= ST_EMPTY;
			stg_idx_q <= '0;
			stg_ax_q <= '0;
			stg_ay_q <= '0;
			stg_az_q <= '0;
			stg_hits_q <= '0;
			res_valid_q <= 1'b0;
			status_q <= '0;
			idx_q <= '0;
			ax_q <= '0;
			ay_q <= '0;
			az_q <= '0;
			hits_q <= '0;
		end else begin
			// the emit state decides valid itself
			if (res_ready && state_q != S_EMIT)
				res_valid_q <= 1'b0;

			unique case (state_q)
				S_IDLE: begin
					if (vtx_valid) begin
						px_q <= pos_x;
						py_q <= pos_y;
						pz_q <= pos_z;
						sel_q <= cluster_sel;
						stg_ax_q <= '0;
						stg_ay_q <= '0;
						stg_az_q <= '0;
						stg_hits_q <= '0;
						stg_status_q <= ST_EMPTY;
						case (func)
							FN_INSERT: begin
								scan_q <= '0;
								state_q <= S_SCAN;
							end
							FN_READ: begin
								stg_idx_q <= cluster_sel;
								state_q <= (sel_cmp < tot_cmp) ? S_RRD : S_EMIT;
							end
							FN_CLEAR: begin
								total_q <= '0;
								stg_idx_q <= '0;
								state_q <= S_EMIT;
							end
							default: state_q <= S_IDLE;
						endcase
					end
				end
				S_SCAN: begin
					if (issue)
						scan_q <= scan_q + 1'b1;
					if (match) begin
						// first hit wins; drop the reads behind it
						v_s1 <= 1'b0;
						v_s2 <= 1'b0;
						v_s3 <= 1'b0;
						hit_idx_q <= idx_s3;
						state_q <= S_MRD;
					end else begin
						v_s1 <= issue;
						v_s2 <= v_s1;
						v_s3 <= v_s2;
						if (scan_done) begin
							if (total_q == CNT_FULL) begin
								stg_status_q <= ST_FULL;
								stg_idx_q <= '0;
							end else begin
								total_q <= total_q + 1'b1;
								stg_status_q <= ST_NEW;
								stg_idx_q <= tot_ext[IDX_W-1:0];
								stg_ax_q <= px_q;
								stg_ay_q <= py_q;
								stg_az_q <= pz_q;
								stg_hits_q <= HIT_W'(1);
							end
							state_q <= S_EMIT;
						end
					end
				end
				S_MRD: state_q <= S_MWAIT;
				S_MWAIT: begin
					stg_status_q <= ST_JOIN;
					stg_idx_q <= hit_ext[IDX_W-1:0];
					if (rd_q.hits == HIT_MAX) begin
						// saturated: absorbed with no change
						stg_ax_q <= rd_q.avg_x;
						stg_ay_q <= rd_q.avg_y;
						stg_az_q <= rd_q.avg_z;
						stg_hits_q <= rd_q.hits;
						state_q <= S_EMIT;
					end else begin
						ent_q <= '{sum_x: rd_q.sum_x + pxe,
							sum_y: rd_q.sum_y + pye,
							sum_z: rd_q.sum_z + pze,
							hits: rd_q.hits + 1'b1,
							avg_x: rd_q.avg_x,
							avg_y: rd_q.avg_y,
							avg_z: rd_q.avg_z};
						state_q <= S_DINIT;
					end
				end
				S_DINIT: begin
					for (int k = 0; k < 3; k++) begin
						// round to nearest, ties away from zero
						dvd_q[k] <= {1'b0, mag[k]} + DIV_W'(ent_q.hits >> 1);
						rem_q[k] <= '0;
						quo_q[k] <= '0;
					end
					dcnt_q <= '0;
					state_q <= S_DIV;
				end
				S_DIV: begin
					for (int k = 0; k < 3; k++) begin
						dvd_q[k] <= {dvd_q[k][DIV_W-2:0], 1'b0};
						rem_q[k] <= rem_n[k];
						quo_q[k] <= {quo_q[k][DIV_W-2:0], qbit[k]};
					end
					dcnt_q <= dcnt_q + 1'b1;
					if (dcnt_q == DCNT_W'(DIV_W - 1))
						state_q <= S_WRB;
				end
				S_WRB: begin
					stg_ax_q <= avg_n[0];
					stg_ay_q <= avg_n[1];
					stg_az_q <= avg_n[2];
					stg_hits_q <= ent_q.hits;
					state_q <= S_EMIT;
				end
				S_RRD: state_q <= S_RWAIT;
				S_RWAIT: begin
					stg_status_q <= ST_READ;
					stg_ax_q <= rd_q.avg_x;
					stg_ay_q <= rd_q.avg_y;
					stg_az_q <= rd_q.avg_z;
					stg_hits_q <= rd_q.hits;
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (!res_valid_q || res_ready) begin
						res_valid_q <= 1'b1;
						status_q <= stg_status_q;
						idx_q <= stg_idx_q;
						ax_q <= stg_ax_q;
						ay_q <= stg_ay_q;
						az_q <= stg_az_q;
						hits_q <= stg_hits_q;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign res_valid = res_valid_q;
	assign status = status_q;
	assign cluster_index = idx_q;
	assign avg_x = ax_q;
	assign avg_y = ay_q;
	assign avg_z = az_q;
	assign hit_count = hits_q;

endmodule

### rtl/core/vwc_chk.sv
`timescale 1ns / 1ps

module vwc_chk import vwc_pkg::*; (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    res_valid,
	input logic                    res_ready,
	input logic [STA_W-1:0]        status,
	input logic [IDX_W-1:0]        cluster_index,
	input logic signed [CRD_W-1:0] avg_x,
	input logic signed [CRD_W-1:0] avg_y,
	input logic signed [CRD_W-1:0] avg_z,
	input logic [HIT_W-1:0]        hit_count
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(status) && $stable(hit_count))
		else $error("result word dropped or changed while stalled");

	a_new: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && status == ST_NEW |-> hit_count == HIT_W'(1))
		else $error("new cluster without a single hit");

	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && status == ST_FULL |-> cluster_index == '0 && hit_count == '0
			&& avg_x == '0 && avg_y == '0 && avg_z == '0)
		else $error("table full word not zeroed");

	a_hits: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (status == ST_JOIN || status == ST_READ) |-> hit_count != '0)
		else $error("live cluster with zero hits");

endmodule

bind vertex_weld_cluster vwc_chk u_vwc_chk (.*);
